[hdl/wrapping_timer_frequency_meter_top_macros.svh]
// Assertion macros for the wrapping timer frequency meter top level.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef WRAPPING_TIMER_FREQUENCY_METER_TOP_MACROS_SVH
`define WRAPPING_TIMER_FREQUENCY_METER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WTFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtfm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WTFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wtfm: next-cycle check failed");

`endif

[hdl/wtfm_pkg.sv]
// Shared constants for the wrapping timer frequency meter.
// No dependencies.
`default_nettype none

package wtfm_pkg;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_REF_FREQ = 2'd1,
    REG_WINDOW   = 2'd2
  } reg_idx_t;

  localparam logic [31:0] REF_FREQ_RST = 32'd3579545;
  localparam logic [31:0] WINDOW_RST   = 32'd10000000;
  localparam logic [31:0] MASK_24      = 32'h00FF_FFFF;
  localparam logic [63:0] SPAN_24      = 64'h0000_0000_0100_0000;
  localparam logic [63:0] SPAN_32      = 64'h0000_0001_0000_0000;
  localparam logic [5:0]  DIV_LAST     = 6'd63;

endpackage

`default_nettype wire

[hdl/wrapping_timer_frequency_meter_top.sv]
// A word that closes no window is taken while in_ready is high; the next word may follow at once.
// A word that closes the window holds in_ready low (without the divider if the result saturates) for
// two 32x32 multiplier passes, a sum, a range check and a 64-step divider on one subtractor.
// Its result is posted as in_ready returns, later while the output register is still full.
// Reset (rst_n, synchronous, active low): idle, registers at defaults, no result pending.
// Depends on wtfm_pkg and wrapping_timer_frequency_meter_top_macros.svh.
`default_nettype none

module wrapping_timer_frequency_meter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_start_req,
  input  wire logic [31:0] in_timer_sample,
  input  wire logic [63:0] in_cycle_count,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_frequency,
  output logic [63:0]      out_tick_delta,
  output logic [63:0]      out_cycle_delta,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Sequencer: IDLE takes words; the rest runs the multiply-divide once per window.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t      state_r, state_nxt;

  // configuration registers
  logic        mode_r, mode_nxt;          // 1 = 32-bit reference timer
  logic [31:0] ref_freq_r, ref_freq_nxt;
  logic [31:0] window_r, window_nxt;

  // measurement state
  logic        measuring_r, measuring_nxt;
  logic [31:0] base_timer_r, base_timer_nxt;
  logic [63:0] base_cycles_r, base_cycles_nxt;
  logic [31:0] prev_timer_r, prev_timer_nxt;
  logic [63:0] wrap_total_r, wrap_total_nxt;

  // arithmetic datapath
  logic [63:0] ticks_r, ticks_nxt;        // divisor and tick_delta
  logic [63:0] dcyc_r, dcyc_nxt;          // cycle_delta
  logic [63:0] p_lo_r, p_lo_nxt;
  logic [63:0] p_hi_r, p_hi_nxt;
  logic [63:0] rem_r, rem_nxt;            // partial remainder
  logic [63:0] quo_r, quo_nxt;            // dividend bits out, quotient bits in
  logic [5:0]  cnt_r, cnt_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_freq_r, out_freq_nxt;
  logic [63:0] out_ticks_r, out_ticks_nxt;
  logic [63:0] out_cyc_r, out_cyc_nxt;

  // combinational helpers
  logic [31:0] cur_sample;
  logic [63:0] wrap_sum;
  logic [63:0] ticks_now;
  logic        window_hit;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [95:0] prod_sum;
  logic [63:0] div_shift;
  logic [64:0] div_diff;
  logic        div_take;
  logic        cfg_wr;
  logic        done_go;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_frequency = out_freq_r;
  assign out_tick_delta = out_ticks_r;
  assign out_cycle_delta = out_cyc_r;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Mask the sample to the current timer width; a drop counts as one wrap.
  assign cur_sample = mode_r ? in_timer_sample : (in_timer_sample & wtfm_pkg::MASK_24);
  assign wrap_sum = (cur_sample < prev_timer_r)
                  ? wrap_total_r + (mode_r ? wtfm_pkg::SPAN_32 : wtfm_pkg::SPAN_24)
                  : wrap_total_r;
  assign ticks_now = {32'd0, cur_sample} + wrap_sum - {32'd0, base_timer_r};
  assign window_hit = (ticks_now >= {32'd0, window_r});

  // One 32x32 multiplier, used for the low then the high half of cycle_delta.
  assign mul_b = (state_r == ST_MUL_HI) ? dcyc_r[63:32] : dcyc_r[31:0];
  assign mul_p = 64'(mul_b) * 64'(ref_freq_r);
  assign prod_sum = {32'd0, p_lo_r} + {p_hi_r, 32'd0};

  // Restoring divide step: shift in the next dividend bit, subtract if it fits.
  assign div_shift = {rem_r[62:0], quo_r[63]};
  assign div_diff = {1'b0, div_shift} - {1'b0, ticks_r};
  assign div_take = rem_r[63] || !div_diff[64];

  // Result stage may hand over once the output register is free.
  assign done_go = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      wtfm_pkg::REG_MODE:     prdata = {31'd0, mode_r};
      wtfm_pkg::REG_REF_FREQ: prdata = ref_freq_r;
      wtfm_pkg::REG_WINDOW:   prdata = window_r;
      default:                prdata = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    ref_freq_nxt    = ref_freq_r;
    window_nxt      = window_r;
    measuring_nxt   = measuring_r;
    base_timer_nxt  = base_timer_r;
    base_cycles_nxt = base_cycles_r;
    prev_timer_nxt  = prev_timer_r;
    wrap_total_nxt  = wrap_total_r;
    ticks_nxt       = ticks_r;
    dcyc_nxt        = dcyc_r;
    p_lo_nxt        = p_lo_r;
    p_hi_nxt        = p_hi_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    out_freq_nxt    = out_freq_r;
    out_ticks_nxt   = out_ticks_r;
    out_cyc_nxt     = out_cyc_r;
    // drop the pending result once it is taken
    out_valid_nxt   = out_valid_r && !out_ready;

    // Writes beyond the register list are ignored.
    if (cfg_wr) begin
      case (paddr[3:2])
        wtfm_pkg::REG_MODE:     mode_nxt = pwdata[0];
        wtfm_pkg::REG_REF_FREQ: ref_freq_nxt = pwdata;
        wtfm_pkg::REG_WINDOW:   window_nxt = pwdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_start_req) begin
            // capture the baseline and (re)arm
            base_timer_nxt  = cur_sample;
            prev_timer_nxt  = cur_sample;
            base_cycles_nxt = in_cycle_count;
            wrap_total_nxt  = 64'd0;
            measuring_nxt   = 1'b1;
          end else if (measuring_r) begin
            wrap_total_nxt = wrap_sum;
            prev_timer_nxt = cur_sample;
            if (window_hit) begin
              ticks_nxt     = ticks_now;
              dcyc_nxt      = in_cycle_count - base_cycles_r;
              measuring_nxt = 1'b0;
              state_nxt     = ST_MUL_LO;
            end
          end
        end
      end
      ST_MUL_LO: begin
        p_lo_nxt  = mul_p;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        p_hi_nxt  = mul_p;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        rem_nxt   = {32'd0, prod_sum[95:64]};
        quo_nxt   = prod_sum[63:0];
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // quotient would not fit in 64 bits (or divisor is zero): saturate
        if (rem_r >= ticks_r) begin
          quo_nxt   = '1;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = wtfm_pkg::DIV_LAST;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_take ? div_diff[63:0] : div_shift;
        quo_nxt = {quo_r[62:0], div_take};
        if (cnt_r == 6'd0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (done_go) begin
          out_freq_nxt  = quo_r;
          out_ticks_nxt = ticks_r;
          out_cyc_nxt   = dcyc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= 1'b0;
      ref_freq_r    <= wtfm_pkg::REF_FREQ_RST;
      window_r      <= wtfm_pkg::WINDOW_RST;
      measuring_r   <= 1'b0;
      base_timer_r  <= 32'd0;
      base_cycles_r <= 64'd0;
      prev_timer_r  <= 32'd0;
      wrap_total_r  <= 64'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      ref_freq_r    <= ref_freq_nxt;
      window_r      <= window_nxt;
      measuring_r   <= measuring_nxt;
      base_timer_r  <= base_timer_nxt;
      base_cycles_r <= base_cycles_nxt;
      prev_timer_r  <= prev_timer_nxt;
      wrap_total_r  <= wrap_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    // payload registers: no reset
    ticks_r     <= ticks_nxt;
    dcyc_r      <= dcyc_nxt;
    p_lo_r      <= p_lo_nxt;
    p_hi_r      <= p_hi_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    out_freq_r  <= out_freq_nxt;
    out_ticks_r <= out_ticks_nxt;
    out_cyc_r   <= out_cyc_nxt;
  end

`include "wrapping_timer_frequency_meter_top_macros.svh"

  // The meter is disarmed for the whole multiply-divide.
  `WTFM_ASSERT_NOW(a_busy_disarmed, state_r != ST_IDLE, !measuring_r)
  // A finished result always lands in the output register.
  `WTFM_ASSERT_NEXT(a_done_loads, done_go, out_valid_r && state_r == ST_IDLE)
  // The last divide step leads to the result stage.
  `WTFM_ASSERT_NEXT(a_div_ends, state_r == ST_DIV && cnt_r == 6'd0, state_r == ST_DONE)

endmodule

`default_nettype wire
